// ===== rtl/core/rbj_pkg.sv =====
// ----------------------------------------------------------------------------
// rbj_pkg - retry backoff with jitter, shared definitions
// widths, constants, register map and the payload structs passed between
// the pipeline sections
// ----------------------------------------------------------------------------
`default_nettype none

package rbj_pkg;

    // field widths
    localparam int unsigned ATTEMPT_W = 16;
    localparam int unsigned HINT_W    = 32;
    localparam int unsigned WAIT_W    = 32;
    localparam int unsigned DELAY_W   = 30;
    localparam int unsigned PCT_W     = 7;
    localparam int unsigned HASH_W    = 32;
    localparam int unsigned SHIFT_W   = $clog2(DELAY_W);

    // delay * percent, and the spread derived from it
    localparam int unsigned PROD_W    = DELAY_W + PCT_W;
    localparam int unsigned QUART_W   = PROD_W - 2;
    localparam int unsigned SPREAD_W  = DELAY_W + 1;
    localparam int unsigned DIVR_W    = SPREAD_W + 1;

    // apb register file
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 4;

    typedef enum logic [1:0] {
        REG_BASE_BACKOFF = 2'd0,
        REG_MAX_BACKOFF  = 2'd1,
        REG_JITTER_PCT   = 2'd2,
        REG_HASH_SEED    = 2'd3
    } reg_idx_t;

    localparam logic [DELAY_W-1:0] BASE_RESET = DELAY_W'(500);
    localparam logic [DELAY_W-1:0] MAX_RESET  = DELAY_W'(60000);
    localparam logic [PCT_W-1:0]   PCT_RESET  = '0;
    localparam logic [HASH_W-1:0]  SEED_RESET = '0;

    // hash mixing
    localparam logic [HASH_W-1:0] GOLDEN_MUL = 32'd2654435761;
    localparam int unsigned SHIFT_A = 13;
    localparam int unsigned SHIFT_B = 17;
    localparam int unsigned SHIFT_C = 5;

    // percent division: x/100 == (x/4)/25, the /25 done by a reciprocal
    // multiply on the top 32 bits of x/4, floor(2^35 / 25)
    localparam int unsigned PCT_DIV   = 100;
    localparam int unsigned PCT_DIV_Q = PCT_DIV / 4;
    localparam logic [31:0] RECIP_25  = 32'd1374389534;

    // remainder divider, quotient bits resolved per stage
    localparam int unsigned DIV_STEP_DEF = 2;

    typedef struct packed {
        logic [DELAY_W-1:0] base_backoff;
        logic [DELAY_W-1:0] max_backoff;
        logic [PCT_W-1:0]   jitter_pct;
        logic [HASH_W-1:0]  hash_seed;
    } cfg_t;

    typedef struct packed {
        logic [DELAY_W-1:0] delay;
        logic [HASH_W-1:0]  hash;
        logic [HINT_W-1:0]  hint;
    } dly_item_t;

    typedef struct packed {
        logic [DELAY_W-1:0]  delay;
        logic [HASH_W-1:0]   hash;
        logic [HINT_W-1:0]   hint;
        logic [SPREAD_W-1:0] spread;
    } spr_item_t;

    typedef struct packed {
        logic [DELAY_W-1:0] delay;
        logic [HINT_W-1:0]  hint;
        logic [DIVR_W-1:0]  jitter;
    } mod_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/rbj_if.sv =====
// ----------------------------------------------------------------------------
// rbj_if - request and response channels
// valid/ready channels carrying the attempt request and the wait response
// ----------------------------------------------------------------------------
`default_nettype none

interface rbj_req_if
    import rbj_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [ATTEMPT_W-1:0] attempt_no;
    logic [HINT_W-1:0]    hint_ms;

    modport source (output valid, output attempt_no, output hint_ms, input ready);
    modport sink   (input valid, input attempt_no, input hint_ms, output ready);
endinterface

interface rbj_rsp_if
    import rbj_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [WAIT_W-1:0] wait_ms;

    modport source (output valid, output wait_ms, input ready);
    modport sink   (input valid, input wait_ms, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/retry_backoff_with_jitter.sv =====
// path: a request passes the delay, spread, divider and output stages on its way
//   to the response, the divider taking two quotient bits per stage by default
// throughput: one request per cycle; every stage has its own valid bit, so a
//   held response only stalls stages that are full and bubbles close up
// reset: configuration registers return to base 500, max 60000, jitter 0,
//   seed 0; all pipeline valid bits clear, payload registers are not reset
// ----------------------------------------------------------------------------
// retry_backoff_with_jitter - exponential retry backoff with hashed jitter
// one wait time per failed attempt: doubled base, clamped, plus a jitter
// term of hash mod (spread + 1), clamped again and raised to the server hint
// ----------------------------------------------------------------------------
`default_nettype none

module retry_backoff_with_jitter
    import rbj_pkg::*;
#(
    parameter int unsigned DIV_STEP = DIV_STEP_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    // apb configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,

    // request and response channels
    rbj_req_if.sink                    req,
    rbj_rsp_if.source                  rsp
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [DELAY_W-1:0] base_reg;
    logic [DELAY_W-1:0] max_reg;
    logic [PCT_W-1:0]   pct_reg;
    logic [HASH_W-1:0]  seed_reg;
    logic               wr_en;
    reg_idx_t           reg_idx;
    cfg_t               cfg;

    assign pready  = 1'b1;
    // write completes in the access phase; pready is tied high
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = reg_idx_t'(paddr[3:2]);

    assign cfg.base_backoff = base_reg;
    assign cfg.max_backoff  = max_reg;
    assign cfg.jitter_pct   = pct_reg;
    assign cfg.hash_seed    = seed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= BASE_RESET;
            max_reg  <= MAX_RESET;
            pct_reg  <= PCT_RESET;
            seed_reg <= SEED_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_BASE_BACKOFF: base_reg <= pwdata[DELAY_W-1:0];
                REG_MAX_BACKOFF:  max_reg  <= pwdata[DELAY_W-1:0];
                REG_JITTER_PCT:   pct_reg  <= pwdata[PCT_W-1:0];
                REG_HASH_SEED:    seed_reg <= pwdata[HASH_W-1:0];
                default:          ;
            endcase
        end
    end

    // read-back, zero extended
    always_comb
    begin
        case (reg_idx)
            REG_BASE_BACKOFF: prdata = APB_DATA_W'(base_reg);
            REG_MAX_BACKOFF:  prdata = APB_DATA_W'(max_reg);
            REG_JITTER_PCT:   prdata = APB_DATA_W'(pct_reg);
            REG_HASH_SEED:    prdata = APB_DATA_W'(seed_reg);
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // stages 1-2: doubled and clamped delay, xorshift hash of the attempt
    // ------------------------------------------------------------------
    logic      dly_valid;
    logic      dly_ready;
    dly_item_t dly_item;

    rbj_delay u_delay (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .up_valid   (req.valid),
        .up_ready   (req.ready),
        .attempt_no (req.attempt_no),
        .hint_ms    (req.hint_ms),
        .dn_valid   (dly_valid),
        .dn_ready   (dly_ready),
        .dn_item    (dly_item)
    );

    // ------------------------------------------------------------------
    // stages 3-5: spread = delay * percent / 100
    // ------------------------------------------------------------------
    logic      spr_valid;
    logic      spr_ready;
    spr_item_t spr_item;

    rbj_spread u_spread (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .up_valid (dly_valid),
        .up_ready (dly_ready),
        .up_item  (dly_item),
        .dn_valid (spr_valid),
        .dn_ready (spr_ready),
        .dn_item  (spr_item)
    );

    // ------------------------------------------------------------------
    // divider stages: jitter = hash mod (spread + 1); a zero spread gives
    // a divisor of one and so no jitter, with no special handling
    // ------------------------------------------------------------------
    logic      mod_valid;
    logic      mod_ready;
    mod_item_t mod_item;

    rbj_mod #(
        .DIV_STEP (DIV_STEP)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (spr_valid),
        .up_ready (spr_ready),
        .up_item  (spr_item),
        .dn_valid (mod_valid),
        .dn_ready (mod_ready),
        .dn_item  (mod_item)
    );

    // ------------------------------------------------------------------
    // last two stages: add jitter and clamp, then raise to the hint in the
    // response register
    // ------------------------------------------------------------------
    logic [1:0]          vld_reg;
    logic                en_sum;
    logic                en_out;
    logic [DIVR_W:0]     sum;
    logic [DELAY_W-1:0]  clamp_next;
    logic [DELAY_W-1:0]  clamp_reg;
    logic [HINT_W-1:0]   hint_reg;
    logic [WAIT_W-1:0]   clamp_ext;
    logic [WAIT_W-1:0]   wait_next;
    logic [WAIT_W-1:0]   wait_reg;

    assign en_out    = !vld_reg[1] || rsp.ready;
    assign en_sum    = !vld_reg[0] || en_out;
    assign mod_ready = en_sum;

    // the delay never exceeds the maximum, so only the sum needs clamping
    assign sum        = (DIVR_W+1)'(mod_item.delay) + (DIVR_W+1)'(mod_item.jitter);
    assign clamp_next = (sum > (DIVR_W+1)'(max_reg)) ? max_reg : sum[DELAY_W-1:0];

    assign clamp_ext = WAIT_W'(clamp_reg);
    assign wait_next = (hint_reg > clamp_ext) ? hint_reg : clamp_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en_sum)
            begin
                vld_reg[0] <= mod_valid;
            end
            if (en_out)
            begin
                vld_reg[1] <= vld_reg[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_sum)
        begin
            clamp_reg <= clamp_next;
            hint_reg  <= mod_item.hint;
        end
        if (en_out)
        begin
            wait_reg <= wait_next;
        end
    end

    assign rsp.valid   = vld_reg[1];
    assign rsp.wait_ms = wait_reg;

endmodule

`default_nettype wire

// ===== rtl/core/rbj_delay.sv =====
// ----------------------------------------------------------------------------
// rbj_delay - doubled delay and jitter hash
// two stages: shift of the base and hash multiply, then saturation and
// xorshift mixing
// ----------------------------------------------------------------------------
`default_nettype none

module rbj_delay
    import rbj_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cfg_t                 cfg,
    input  wire logic                 up_valid,
    output logic                      up_ready,
    input  wire logic [ATTEMPT_W-1:0] attempt_no,
    input  wire logic [HINT_W-1:0]    hint_ms,
    output logic                      dn_valid,
    input  wire logic                 dn_ready,
    output dly_item_t                 dn_item
);

    logic [1:0] vld_reg;
    logic       en_a;
    logic       en_b;

    logic [ATTEMPT_W-1:0]        dbl_cnt;
    logic                        sat_next;
    logic [2*DELAY_W-1:0]        shl_next;
    logic [ATTEMPT_W+HASH_W-1:0] hprod_full;

    logic                 sat_reg;
    logic [2*DELAY_W-1:0] shl_reg;
    logic [HASH_W-1:0]    hprod_reg;
    logic [HINT_W-1:0]    hint_reg;

    logic [HASH_W-1:0] mix0;
    logic [HASH_W-1:0] mix1;
    logic [HASH_W-1:0] mix2;
    logic [HASH_W-1:0] mix3;
    logic [DELAY_W-1:0] delay_next;

    dly_item_t item_reg;

    assign en_b     = !vld_reg[1] || dn_ready;
    assign en_a     = !vld_reg[0] || en_b;
    assign up_ready = en_a;
    assign dn_valid = vld_reg[1];
    assign dn_item  = item_reg;

    // attempts 0 and 1 double nothing
    assign dbl_cnt  = (attempt_no > ATTEMPT_W'(1)) ? attempt_no - ATTEMPT_W'(1) : '0;
    // a nonzero base shifted by the delay width already passes any maximum
    assign sat_next = (dbl_cnt >= ATTEMPT_W'(DELAY_W)) && (cfg.base_backoff != '0);
    assign shl_next = {{DELAY_W{1'b0}}, cfg.base_backoff} << dbl_cnt[SHIFT_W-1:0];
    assign hprod_full = {{HASH_W{1'b0}}, attempt_no} * {{ATTEMPT_W{1'b0}}, GOLDEN_MUL};

    assign mix0 = cfg.hash_seed ^ hprod_reg;
    assign mix1 = mix0 ^ (mix0 << SHIFT_A);
    assign mix2 = mix1 ^ (mix1 >> SHIFT_B);
    assign mix3 = mix2 ^ (mix2 << SHIFT_C);

    assign delay_next = (sat_reg || (shl_reg > {{DELAY_W{1'b0}}, cfg.max_backoff}))
                      ? cfg.max_backoff : shl_reg[DELAY_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en_a)
            begin
                vld_reg[0] <= up_valid;
            end
            if (en_b)
            begin
                vld_reg[1] <= vld_reg[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            sat_reg   <= sat_next;
            shl_reg   <= shl_next;
            hprod_reg <= hprod_full[HASH_W-1:0];
            hint_reg  <= hint_ms;
        end
        if (en_b)
        begin
            item_reg.delay <= delay_next;
            item_reg.hash  <= mix3;
            item_reg.hint  <= hint_reg;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/rbj_spread.sv =====
// ----------------------------------------------------------------------------
// rbj_spread - jitter spread
// three stages: delay times percent, reciprocal estimate of the quotient
// by 100, one-step correction
// ----------------------------------------------------------------------------
`default_nettype none

module rbj_spread
    import rbj_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cfg_t      cfg,
    input  wire logic      up_valid,
    output logic           up_ready,
    input  wire dly_item_t up_item,
    output logic           dn_valid,
    input  wire logic      dn_ready,
    output spr_item_t      dn_item
);

    logic [2:0] vld_reg;
    logic       en_c;
    logic       en_d;
    logic       en_e;

    logic [PROD_W-1:0] prod_next;
    logic [63:0]       recip_prod;
    logic [QUART_W-1:0] q25;
    logic [QUART_W-1:0] rem25;
    logic [SPREAD_W-1:0] spread_next;

    dly_item_t           c_item_reg;
    logic [PROD_W-1:0]   prod_reg;
    dly_item_t           d_item_reg;
    logic [QUART_W-1:0]  quart_reg;
    logic [SPREAD_W-1:0] qest_reg;
    spr_item_t           item_reg;

    assign en_e     = !vld_reg[2] || dn_ready;
    assign en_d     = !vld_reg[1] || en_e;
    assign en_c     = !vld_reg[0] || en_d;
    assign up_ready = en_c;
    assign dn_valid = vld_reg[2];
    assign dn_item  = item_reg;

    assign prod_next = {{PCT_W{1'b0}}, up_item.delay} * {{DELAY_W{1'b0}}, cfg.jitter_pct};

    // estimate is at most one below the true quotient
    assign recip_prod = {32'b0, prod_reg[PROD_W-1:5]} * {32'b0, RECIP_25};

    assign q25   = QUART_W'(qest_reg) * QUART_W'(PCT_DIV_Q);
    assign rem25 = quart_reg - q25;
    assign spread_next = (rem25 >= QUART_W'(PCT_DIV_Q)) ? qest_reg + SPREAD_W'(1) : qest_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en_c)
            begin
                vld_reg[0] <= up_valid;
            end
            if (en_d)
            begin
                vld_reg[1] <= vld_reg[0];
            end
            if (en_e)
            begin
                vld_reg[2] <= vld_reg[1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_c)
        begin
            c_item_reg <= up_item;
            prod_reg   <= prod_next;
        end
        if (en_d)
        begin
            d_item_reg <= c_item_reg;
            quart_reg  <= prod_reg[PROD_W-1:2];
            qest_reg   <= recip_prod[32+SPREAD_W-1:32];
        end
        if (en_e)
        begin
            item_reg.delay  <= d_item_reg.delay;
            item_reg.hash   <= d_item_reg.hash;
            item_reg.hint   <= d_item_reg.hint;
            item_reg.spread <= spread_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/rbj_mod.sv =====
// ----------------------------------------------------------------------------
// rbj_mod - pipelined remainder
// restoring division of the hash by spread + 1, DIV_STEP bits per stage,
// only the remainder is kept
// ----------------------------------------------------------------------------
`default_nettype none

module rbj_mod
    import rbj_pkg::*;
#(
    parameter int unsigned DIV_STEP = DIV_STEP_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      up_valid,
    output logic           up_ready,
    input  wire spr_item_t up_item,
    output logic           dn_valid,
    input  wire logic      dn_ready,
    output mod_item_t      dn_item
);

    localparam int unsigned NSTAGE = HASH_W / DIV_STEP;

    typedef struct packed {
        logic [DELAY_W-1:0] delay;
        logic [HINT_W-1:0]  hint;
        logic [HASH_W-1:0]  hash;
        logic [DIVR_W-1:0]  dvsr;
        logic [DIVR_W-1:0]  rem;
    } div_stage_t;

    logic [NSTAGE-1:0] vld_reg;
    logic [NSTAGE-1:0] en;
    div_stage_t        stg_reg [NSTAGE];
    div_stage_t        stg_in  [NSTAGE];
    div_stage_t        head;

    always_comb
    begin
        head.delay = up_item.delay;
        head.hint  = up_item.hint;
        head.hash  = up_item.hash;
        head.dvsr  = {1'b0, up_item.spread} + DIVR_W'(1);
        head.rem   = '0;
    end

    genvar s;
    generate
        for (s = 0; s < NSTAGE; s++)
        begin : g_stage
            div_stage_t src;
            logic [DIVR_W-1:0] rem_next;

            if (s == 0)
            begin : g_head
                assign src = head;
            end
            else
            begin : g_body
                assign src = stg_reg[s-1];
            end

            if (s == NSTAGE - 1)
            begin : g_last
                assign en[s] = !vld_reg[s] || dn_ready;
            end
            else
            begin : g_mid
                assign en[s] = !vld_reg[s] || en[s+1];
            end

            // shift in one dividend bit, subtract when the divisor fits
            always_comb
            begin
                logic [DIVR_W:0] trial;
                rem_next = src.rem;
                for (int j = 0; j < DIV_STEP; j++)
                begin
                    trial = {rem_next, src.hash[HASH_W-1-s*DIV_STEP-j]};
                    if (trial >= {1'b0, src.dvsr})
                    begin
                        trial = trial - {1'b0, src.dvsr};
                    end
                    rem_next = trial[DIVR_W-1:0];
                end
            end

            always_comb
            begin
                stg_in[s]     = src;
                stg_in[s].rem = rem_next;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[s] <= 1'b0;
                end
                else if (en[s])
                begin
                    vld_reg[s] <= (s == 0) ? up_valid : vld_reg[(s == 0) ? 0 : s-1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[s])
                begin
                    stg_reg[s] <= stg_in[s];
                end
            end
        end
    endgenerate

    assign up_ready       = en[0];
    assign dn_valid       = vld_reg[NSTAGE-1];
    assign dn_item.delay  = stg_reg[NSTAGE-1].delay;
    assign dn_item.hint   = stg_reg[NSTAGE-1].hint;
    assign dn_item.jitter = stg_reg[NSTAGE-1].rem;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench - retry backoff with jitter, self-checking bench
// drives attempt requests through the request channel, works out the wait
// for every accepted request with an independent model of the doubling,
// clamping, hashed jitter and hint logic, and compares each response in
// order; configuration goes in over apb between phases while the pipeline
// is empty, and the idling of both channels changes from phase to phase
// ----------------------------------------------------------------------------
module testbench;
    import rbj_pkg::*;

    // pipeline depth at the default divider step, used for the final settle
    localparam int unsigned PIPE_LATENCY = 23;
    // cycles with no handshake of any kind before the run is declared hung
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned DELAY_TOP    = 604800000;
    localparam int unsigned PHASES       = 8;
    localparam int unsigned BATCH_SIZE   = 68;

    typedef struct {
        logic [ATTEMPT_W-1:0] attempt_no;
        logic [HINT_W-1:0]    hint_ms;
    } attempt_req_t;

    typedef struct {
        logic [ATTEMPT_W-1:0] attempt_no;
        logic [HINT_W-1:0]    hint_ms;
        logic [WAIT_W-1:0]    wait_ms;
    } wait_entry_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    rbj_req_if req_ch ();
    rbj_rsp_if rsp_ch ();

    // requests waiting for the driver, and the waits still owed by the block
    attempt_req_t pending_requests[$];
    wait_entry_t  expected_waits[$];

    // shadow copy of the register file as the block should hold it
    cfg_t         shadow_cfg;

    // percentages of cycles in which the sender idles or the receiver stalls
    int unsigned  idle_pct;
    int unsigned  stall_pct;
    int unsigned  error_count;
    int unsigned  quiet_cycles;

    retry_backoff_with_jitter dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .rsp     (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // xorshift of the seed mixed with the golden-ratio scaled attempt number
    function automatic logic [HASH_W-1:0] jitter_hash(input logic [ATTEMPT_W-1:0] attempt_no);
        logic [HASH_W-1:0] scaled;
        logic [HASH_W-1:0] mix;
        scaled = HASH_W'({16'b0, attempt_no} * GOLDEN_MUL);
        mix    = shadow_cfg.hash_seed ^ scaled;
        mix    = mix ^ (mix << SHIFT_A);
        mix    = mix ^ (mix >> SHIFT_B);
        mix    = mix ^ (mix << SHIFT_C);
        return mix;
    endfunction

    function automatic logic [WAIT_W-1:0] predict_wait(input logic [ATTEMPT_W-1:0] attempt_no,
                                                       input logic [HINT_W-1:0]    hint_ms);
        logic [63:0] delay;
        logic [63:0] ceiling;
        logic [63:0] spread;
        int unsigned doublings;
        ceiling   = 64'(shadow_cfg.max_backoff);
        delay     = 64'(shadow_cfg.base_backoff);
        doublings = (attempt_no > 1) ? attempt_no - 1 : 0;
        if (doublings > 40)
        begin
            doublings = 40;
        end
        // doubling stops at the ceiling; above half of it the delay jumps there
        while (doublings != 0 && delay < ceiling)
        begin
            doublings--;
            if (delay > ceiling / 2)
            begin
                delay     = ceiling;
                doublings = 0;
            end
            else
            begin
                delay = delay * 2;
            end
        end
        if (delay > ceiling)
        begin
            delay = ceiling;
        end
        spread = (delay * 64'(shadow_cfg.jitter_pct)) / 64'(PCT_DIV);
        // no spread, no jitter
        if (spread != 0)
        begin
            delay = delay + (64'(jitter_hash(attempt_no)) % (spread + 1));
            if (delay > ceiling)
            begin
                delay = ceiling;
            end
        end
        if (64'(hint_ms) > delay)
        begin
            delay = 64'(hint_ms);
        end
        return delay[WAIT_W-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // request driver: next request goes out once the current one is taken
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        attempt_req_t next_req;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                next_req           = pending_requests.pop_front();
                req_ch.valid      <= 1'b1;
                req_ch.attempt_no <= next_req.attempt_no;
                req_ch.hint_ms    <= next_req.hint_ms;
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // response back-pressure, redrawn every cycle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // monitor: predict on every accepted request, check every accepted
    // response against the oldest outstanding wait
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : wait_monitor
        wait_entry_t owed;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                owed.attempt_no = req_ch.attempt_no;
                owed.hint_ms    = req_ch.hint_ms;
                owed.wait_ms    = predict_wait(req_ch.attempt_no, req_ch.hint_ms);
                expected_waits.push_back(owed);
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_waits.size() == 0)
                begin
                    $error("unexpected response: wait_ms %0d with no request outstanding",
                           rsp_ch.wait_ms);
                    error_count++;
                end
                else
                begin
                    owed = expected_waits.pop_front();
                    if (rsp_ch.wait_ms !== owed.wait_ms)
                    begin
                        $error("wait_ms mismatch: expected %0d, actual %0d (attempt %0d, hint %0d)",
                               owed.wait_ms, rsp_ch.wait_ms, owed.attempt_no, owed.hint_ms);
                        error_count++;
                    end
                end
            end
        end
    end

    // watchdog: any handshake on either channel or the apb port counts as progress
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (psel && penable))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $error("no handshake for %0d cycles, %0d responses outstanding",
                   quiet_cycles, expected_waits.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // apb write: setup then access; the register takes the value on the
    // access edge, so the shadow copy follows at the same point
    task automatic write_reg(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_BASE_BACKOFF: shadow_cfg.base_backoff = value[DELAY_W-1:0];
            REG_MAX_BACKOFF:  shadow_cfg.max_backoff  = value[DELAY_W-1:0];
            REG_JITTER_PCT:   shadow_cfg.jitter_pct   = value[PCT_W-1:0];
            REG_HASH_SEED:    shadow_cfg.hash_seed    = value[HASH_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_backoff(input logic [31:0] base_ms, input logic [31:0] max_ms,
                                   input logic [31:0] pct, input logic [31:0] seed);
        write_reg(REG_BASE_BACKOFF, base_ms);
        write_reg(REG_MAX_BACKOFF,  max_ms);
        write_reg(REG_JITTER_PCT,   pct);
        write_reg(REG_HASH_SEED,    seed);
    endtask

    task automatic queue_request(input logic [ATTEMPT_W-1:0] attempt_no,
                                 input logic [HINT_W-1:0]    hint_ms);
        attempt_req_t item;
        item.attempt_no = attempt_no;
        item.hint_ms    = hint_ms;
        pending_requests.push_back(item);
    endtask

    // sender holds off until every request has been answered
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || req_ch.valid || expected_waits.size() != 0);
    endtask

    // delay register value biased towards the ends of its range
    function automatic logic [31:0] pick_delay();
        case ($urandom_range(5))
            0:       return 32'd0;
            1:       return DELAY_TOP;
            2:       return $urandom_range(1, 5000);
            3:       return $urandom_range(5000, 2000000);
            default: return $urandom_range(0, DELAY_TOP);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_sequence
        logic [31:0] base_ms;
        logic [31:0] max_ms;
        logic [31:0] pct;
        logic [31:0] swap;
        logic [ATTEMPT_W-1:0] attempt_no;
        logic [HINT_W-1:0]    hint_ms;

        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        req_ch.valid      = 1'b0;
        req_ch.attempt_no = '0;
        req_ch.hint_ms    = '0;
        rsp_ch.ready      = 1'b0;
        idle_pct          = 0;
        stall_pct         = 0;
        error_count       = 0;
        quiet_cycles      = 0;

        shadow_cfg.base_backoff = BASE_RESET;
        shadow_cfg.max_backoff  = MAX_RESET;
        shadow_cfg.jitter_pct   = PCT_RESET;
        shadow_cfg.hash_seed    = SEED_RESET;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset register values, attempt zero alongside the first attempt
        queue_request(16'd1, 32'd0);
        queue_request(16'd0, 32'd0);
        queue_request(16'd2, 32'd0);
        queue_request(16'd8, 32'd0);
        queue_request(16'hFFFF, 32'd0);
        queue_request(16'd3, 32'hFFFF_FFFF);
        wait_drained();

        // full-range ceiling, full jitter, seed of all ones
        program_backoff(32'd1, DELAY_TOP, 32'd100, 32'hFFFF_FFFF);
        queue_request(16'd0, 32'd0);
        queue_request(16'd1, 32'd0);
        queue_request(16'd2, 32'h5555_5555);
        queue_request(16'd30, 32'd0);
        queue_request(16'd31, 32'd0);
        queue_request(16'hAAAA, 32'd0);
        queue_request(16'h5555, 32'd0);
        queue_request(16'hFFFF, 32'hAAAA_AAAA);
        wait_drained();

        // base above the ceiling, percentage beyond a hundred
        program_backoff(DELAY_TOP, 32'd1000, 32'd127, 32'h1234_5678);
        queue_request(16'd1, 32'd0);
        queue_request(16'd3, 32'd0);
        queue_request(16'hFFFF, 32'd0);
        wait_drained();

        // zero base stays zero however many attempts have failed
        program_backoff(32'd0, DELAY_TOP, 32'd50, 32'h9E37_79B9);
        queue_request(16'd1, 32'd0);
        queue_request(16'd100, 32'd5);
        queue_request(16'hFFFF, 32'd0);
        wait_drained();

        // spread rounds down to nothing
        program_backoff(32'd3, 32'd3, 32'd20, 32'd0);
        queue_request(16'd5, 32'd0);
        queue_request(16'd1, 32'd2);
        wait_drained();

        // zero ceiling, only the hint can lift the wait
        program_backoff(32'd777, 32'd0, 32'd100, 32'hFFFF_0000);
        queue_request(16'd4, 32'd0);
        queue_request(16'd1, 32'd7);
        wait_drained();

        // random phases, each with its own settings and idling pattern
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 65; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 65; end
                default: begin idle_pct = 15; stall_pct = 15; end
            endcase

            base_ms = pick_delay();
            max_ms  = pick_delay();
            // mostly a ceiling at or above the base, sometimes not
            if (base_ms > max_ms && $urandom_range(3) != 0)
            begin
                swap    = base_ms;
                base_ms = max_ms;
                max_ms  = swap;
            end
            case ($urandom_range(5))
                0:       pct = 32'd0;
                1:       pct = $urandom_range(101, 127);
                2:       pct = 32'd100;
                default: pct = $urandom_range(1, 100);
            endcase
            program_backoff(base_ms, max_ms, pct, $urandom);

            // two batches per phase, the sender pausing for the pipeline to empty
            for (int batch = 0; batch < 2; batch++)
            begin
                for (int n = 0; n < BATCH_SIZE; n++)
                begin
                    // small attempt numbers exercise the doubling, the rest all bits
                    if ($urandom_range(9) < 7)
                    begin
                        attempt_no = ATTEMPT_W'($urandom_range(0, 45));
                    end
                    else
                    begin
                        attempt_no = ATTEMPT_W'($urandom);
                    end
                    case ($urandom_range(9))
                        0, 1, 2, 3, 4: hint_ms = '0;
                        5, 6:          hint_ms = $urandom_range(0, 2000000);
                        7:             hint_ms = 32'hFFFF_FFFF;
                        default:       hint_ms = $urandom;
                    endcase
                    queue_request(attempt_no, hint_ms);
                end
                wait_drained();
            end
        end

        // let anything stray fall out of the pipeline
        repeat (2 * PIPE_LATENCY) @(posedge clk);
        @(negedge clk);

        if (expected_waits.size() != 0)
        begin
            $error("%0d responses never arrived", expected_waits.size());
            error_count++;
        end
        if (error_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
